// ===== src/assert_macros.svh =====
// Assertion macros shared by the translation block cache RTL.
// Plain text macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TBC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tbc_pkg.sv =====
// Types and fixed field widths of the translation block cache.
// No dependencies; used by every module of the block but tbc_ram.
package tbc_pkg;

  localparam int KEY_W     = 64;
  localparam int GLEN_W    = 24;
  localparam int CADDR_W   = 48;
  localparam int CLEN_W    = 24;
  localparam int IDX_OUT_W = 8;

  // Stored row: key, code address, guest length, code length, then use count on top.
  localparam int ROW_KEY_LSB   = 0;
  localparam int ROW_CADDR_LSB = ROW_KEY_LSB + KEY_W;
  localparam int ROW_GLEN_LSB  = ROW_CADDR_LSB + CADDR_W;
  localparam int ROW_CLEN_LSB  = ROW_GLEN_LSB + GLEN_W;
  localparam int ROW_FIXED_W   = ROW_CLEN_LSB + CLEN_W;

  localparam int S_TDATA_W = KEY_W + GLEN_W + CADDR_W + CLEN_W;
  localparam int M_TDATA_W = IDX_OUT_W + 2 * CADDR_W + 3 * CLEN_W;
  localparam int M_TUSER_W = 2;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_INSERT = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_APPEND,
    CMD_EVICT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [KEY_W-1:0]    key;
    logic [GLEN_W-1:0]   glen;
    logic [CADDR_W-1:0]  caddr;
    logic [CLEN_W-1:0]   clen;
  } cmd_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [CADDR_W-1:0]   found_caddr;
    logic [CLEN_W-1:0]    found_clen;
    logic [GLEN_W-1:0]    found_glen;
    logic                 evicted;
    logic [CADDR_W-1:0]   ev_caddr;
    logic [CLEN_W-1:0]    ev_clen;
  } res_t;

endpackage

// ===== src/translation_block_cache_lfu.sv =====
// Top level of the translation block cache with least-frequently-used replacement.
// Depends on tbc_pkg, tbc_front and tbc_back (which holds the tbc_ram entry store).
//
// Use: one input word per request on the s_axis side. tuser selects the action
// (0 lookup by guest address, 1 insert); tdata carries the key and the lengths and
// host address stored on insert. Every accepted word yields exactly one result word
// on the m_axis side, in order. tuser[0] flags a lookup hit, tuser[1] an eviction.
// An insert while the table has room is written without a scan. A lookup scans
// the rows in index order up to the first match, or all filled entries on a miss
// (no scan on an empty table); an insert into a full table scans all ENTRIES rows
// for the victim. The scan reads one row per cycle from the single read port of
// the entry RAM, and the back end takes one word at a time.
// A two-word queue sits between the front end and the back end, so a new word is
// taken while the previous one is scanned or while its result waits.
// Reset clears the fill count and all handshake state; the entry RAM is not
// cleared, only filled rows are ever read. When the receiver stalls, the result
// stays in the output register, the back end holds its next result, and once the
// queue is full s_axis_tready drops.
module translation_block_cache_lfu import tbc_pkg::*; #(
  parameter int ENTRIES    = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [63:0] guest_address, [87:64] guest_length, [135:88] host_code_address,
  // [159:136] host_code_length
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] action
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] entry_index, [55:8] found_code_address, [79:56] found_code_length,
  // [103:80] found_guest_length, [151:104] evicted_code_address,
  // [175:152] evicted_code_length
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] hit, [1] evicted
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  localparam int FILL_W = $clog2(ENTRIES + 1);

  logic              q_valid, q_ready;
  cmd_t              q_cmd;
  logic [FILL_W-1:0] q_fill;
  res_t              res;

  tbc_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_cmd_o     (q_cmd),
    .q_fill_o    (q_fill)
  );

  tbc_back #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_cmd_i     (q_cmd),
    .q_fill_i    (q_fill),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Output word packing, highest field first.
  assign m_axis_tdata = {res.ev_clen, res.ev_caddr, res.found_glen, res.found_clen,
                         res.found_caddr, res.entry_index};
  assign m_axis_tuser = {res.evicted, res.hit};

endmodule

// ===== src/tbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tbc_front.sv =====
// Front end: accepts words, classifies them against the fill count, queues them.
// Depends on tbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbc_front import tbc_pkg::*; #(
  parameter int ENTRIES = 256,
  localparam int FILL_W = $clog2(ENTRIES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_action_i,
  input  logic [S_TDATA_W-1:0] in_data_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output cmd_t                 q_cmd_o,
  output logic [FILL_W-1:0]    q_fill_o
);

  localparam logic [1:0] QDEPTH = 2'd2;
  localparam logic [FILL_W-1:0] FULL = FILL_W'(ENTRIES);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              wr_ptr_q, rd_ptr_q;
  cmd_t              cmd_mem_q [2];
  logic [FILL_W-1:0] fill_mem_q [2];
  cmd_t              new_cmd;
  logic              push, pop;

  assign in_ready_o = (cnt_q != QDEPTH);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_cmd_o    = cmd_mem_q[rd_ptr_q];
  assign q_fill_o   = fill_mem_q[rd_ptr_q];

  // Inserts are appended until the table is full; after that each one evicts.
  always_comb begin
    new_cmd.key   = in_data_i[ROW_KEY_LSB +: KEY_W];
    new_cmd.glen  = in_data_i[KEY_W +: GLEN_W];
    new_cmd.caddr = in_data_i[KEY_W + GLEN_W +: CADDR_W];
    new_cmd.clen  = in_data_i[KEY_W + GLEN_W + CADDR_W +: CLEN_W];
    fill_d        = fill_q;
    if (action_e'(in_action_i) == ACT_LOOKUP) begin
      new_cmd.kind = CMD_LOOKUP;
    end else if (fill_q < FULL) begin
      new_cmd.kind = CMD_APPEND;
      if (push) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end else begin
      new_cmd.kind = CMD_EVICT;
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_mem_q[wr_ptr_q]  <= new_cmd;
      fill_mem_q[wr_ptr_q] <= fill_q;
    end
  end

  `TBC_ASSERT_IMPLY(a_queue_bound, clk_i, rst_ni, 1'b1, cnt_q <= QDEPTH, "queue overfilled")
  `TBC_ASSERT_IMPLY(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FULL, "fill count past table size")
  `TBC_ASSERT_IMPLY(a_evict_full, clk_i, rst_ni, push && new_cmd.kind == CMD_EVICT,
                    fill_q == FULL, "eviction issued with room left")
  `TBC_ASSERT_NEXT(a_push_seen, clk_i, rst_ni, push && !pop, q_valid_o, "queued word lost")

endmodule

// ===== src/tbc_back.sv =====
// Back end: scans the entry RAM for lookups and victim search, writes rows, holds the result.
// Depends on tbc_pkg, tbc_ram and assert_macros.svh.
`include "assert_macros.svh"

module tbc_back import tbc_pkg::*; #(
  parameter int ENTRIES    = 256,
  parameter int COUNT_BITS = 16,
  localparam int FILL_W    = $clog2(ENTRIES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cmd_t              q_cmd_i,
  input  logic [FILL_W-1:0] q_fill_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ROW_W = ROW_FIXED_W + COUNT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e                state_q, state_d;
  cmd_t                  cmd_q, cmd_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [FILL_W-1:0]     iss_q, iss_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]      chk_idx_q, chk_idx_d;
  logic [COUNT_BITS-1:0] min_cnt_q, min_cnt_d;
  logic [IDX_W-1:0]      min_idx_q, min_idx_d;
  logic [CADDR_W-1:0]    min_caddr_q, min_caddr_d;
  logic [CLEN_W-1:0]     min_clen_q, min_clen_d;
  res_t                  res_q, res_d;
  logic                  out_vld_q, out_vld_d;
  res_t                  out_res_q, out_res_d;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ROW_W-1:0]      ram_wdata, rd_row;
  logic [COUNT_BITS-1:0] rd_cnt, cnt_inc;
  logic                  last_chk, take_min;
  logic [IDX_W-1:0]      sel_idx;
  logic [CADDR_W-1:0]    sel_caddr;
  logic [CLEN_W-1:0]     sel_clen;

  tbc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_row)
  );

  assign rd_cnt   = rd_row[ROW_FIXED_W +: COUNT_BITS];
  assign cnt_inc  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign last_chk = (FILL_W'(chk_idx_q) + FILL_W'(1) == fill_q);
  // Strict less-than keeps the lowest index on ties.
  assign take_min = (chk_idx_q == '0) || (rd_cnt < min_cnt_q);
  assign sel_idx   = take_min ? chk_idx_q : min_idx_q;
  assign sel_caddr = take_min ? rd_row[ROW_CADDR_LSB +: CADDR_W] : min_caddr_q;
  assign sel_clen  = take_min ? rd_row[ROW_CLEN_LSB +: CLEN_W] : min_clen_q;

  assign res_valid_o = out_vld_q;
  assign res_o       = out_res_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    fill_d      = fill_q;
    iss_d       = iss_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = chk_idx_q;
    min_cnt_d   = min_cnt_q;
    min_idx_d   = min_idx_q;
    min_caddr_d = min_caddr_q;
    min_clen_d  = min_clen_q;
    res_d       = res_q;
    out_vld_d   = out_vld_q && !res_ready_i;
    out_res_d   = out_res_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    q_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          cmd_d  = q_cmd_i;
          fill_d = q_fill_i;
          iss_d  = '0;
          res_d  = '0;
          priority if (q_cmd_i.kind == CMD_APPEND) begin
            // Room left: the new row goes to the next free slot, count zero.
            ram_we    = 1'b1;
            ram_waddr = q_fill_i[IDX_W-1:0];
            ram_wdata = {COUNT_BITS'(0), q_cmd_i.clen, q_cmd_i.glen, q_cmd_i.caddr,
                         q_cmd_i.key};
            res_d.entry_index = IDX_OUT_W'(q_fill_i);
            state_d = ST_RESP;
          end else if (q_cmd_i.kind == CMD_LOOKUP && q_fill_i == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (iss_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = iss_q[IDX_W-1:0];
          iss_d     = iss_q + FILL_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[IDX_W-1:0];
        end
        if (chk_vld_q) begin
          if (cmd_q.kind == CMD_LOOKUP) begin
            if (rd_row[ROW_KEY_LSB +: KEY_W] == cmd_q.key) begin
              ram_we    = 1'b1;
              ram_waddr = chk_idx_q;
              ram_wdata = {cnt_inc, rd_row[ROW_FIXED_W-1:0]};
              res_d.hit         = 1'b1;
              res_d.entry_index = IDX_OUT_W'(chk_idx_q);
              res_d.found_caddr = rd_row[ROW_CADDR_LSB +: CADDR_W];
              res_d.found_clen  = rd_row[ROW_CLEN_LSB +: CLEN_W];
              res_d.found_glen  = rd_row[ROW_GLEN_LSB +: GLEN_W];
              state_d = ST_RESP;
            end else if (last_chk) begin
              state_d = ST_RESP;
            end
          end else begin
            min_cnt_d   = take_min ? rd_cnt : min_cnt_q;
            min_idx_d   = sel_idx;
            min_caddr_d = sel_caddr;
            min_clen_d  = sel_clen;
            if (last_chk) begin
              ram_we    = 1'b1;
              ram_waddr = sel_idx;
              ram_wdata = {COUNT_BITS'(0), cmd_q.clen, cmd_q.glen, cmd_q.caddr, cmd_q.key};
              res_d.evicted     = 1'b1;
              res_d.entry_index = IDX_OUT_W'(sel_idx);
              res_d.ev_caddr    = sel_caddr;
              res_d.ev_clen     = sel_clen;
              state_d = ST_RESP;
            end
          end
        end
      end

      ST_RESP: begin
        if (!out_vld_q || res_ready_i) begin
          out_vld_d = 1'b1;
          out_res_d = res_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      fill_q      <= '0;
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      min_cnt_q   <= '0;
      min_idx_q   <= '0;
      min_caddr_q <= '0;
      min_clen_q  <= '0;
      res_q       <= '0;
      out_vld_q   <= 1'b0;
      out_res_q   <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      fill_q      <= fill_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      min_cnt_q   <= min_cnt_d;
      min_idx_q   <= min_idx_d;
      min_caddr_q <= min_caddr_d;
      min_clen_q  <= min_clen_d;
      res_q       <= res_d;
      out_vld_q   <= out_vld_d;
      out_res_q   <= out_res_d;
    end
  end

  `TBC_ASSERT_IMPLY(a_scan_bound, clk_i, rst_ni, state_q == ST_SCAN, iss_q <= fill_q,
                    "scan ran past filled entries")
  `TBC_ASSERT_IMPLY(a_scan_nonempty, clk_i, rst_ni, state_q == ST_SCAN, fill_q != '0,
                    "scan started on an empty table")
  `TBC_ASSERT_IMPLY(a_no_append_scan, clk_i, rst_ni, state_q == ST_SCAN,
                    cmd_q.kind != CMD_APPEND, "append routed into a scan")
  `TBC_ASSERT_NEXT(a_resp_out, clk_i, rst_ni,
                   state_q == ST_RESP && (!out_vld_q || res_ready_i), out_vld_q,
                   "result dropped on handoff")

endmodule

// ===== tb/translation_block_cache_lfu_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for translation_block_cache_lfu: lookups and inserts go in as
// stream words, and every reply word is checked against an in-bench cache mirror.
// Depends on tbc_pkg and the cache RTL only.
module translation_block_cache_lfu_tb;
  import tbc_pkg::*;

  localparam int ENTRIES     = 256;
  localparam int COUNT_BITS  = 16;
  localparam int RAND_WORDS  = 900;
  // Short run of back-to-back hits on one row with the receiver always ready.
  localparam int SAT_HITS    = 24;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG    = 5000;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  typedef struct {
    action_e             act;
    logic [KEY_W-1:0]    key;
    logic [GLEN_W-1:0]   glen;
    logic [CADDR_W-1:0]  caddr;
    logic [CLEN_W-1:0]   clen;
    int unsigned         gap;   // idle cycles before the word is offered
  } cache_req_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  translation_block_cache_lfu #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Cache mirror: rows, their use counts and the fill level.
  logic [KEY_W-1:0]      key_mem   [ENTRIES];
  logic [CADDR_W-1:0]    caddr_mem [ENTRIES];
  logic [CLEN_W-1:0]     clen_mem  [ENTRIES];
  logic [GLEN_W-1:0]     glen_mem  [ENTRIES];
  logic [COUNT_BITS-1:0] use_mem   [ENTRIES];
  int                    fill_level;

  cache_req_t       pending_requests[$];
  res_t             expected_replies[$];
  logic [KEY_W-1:0] known_keys[$];

  cache_req_t  cur_req;
  res_t        seen_reply;
  int unsigned gap_count;
  int unsigned replies_seen;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned sat_lo, sat_hi, hold_at;
  int unsigned idle_cycles;
  int          mismatches;
  int          n_lookup, n_hit, n_insert, n_evict;
  logic [COUNT_BITS-1:0] peak_count;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_req(action_e act, logic [KEY_W-1:0] key,
                                    logic [GLEN_W-1:0] glen, logic [CADDR_W-1:0] caddr,
                                    logic [CLEN_W-1:0] clen, int unsigned gap);
    cache_req_t r;
    r.act   = act;
    r.key   = key;
    r.glen  = glen;
    r.caddr = caddr;
    r.clen  = clen;
    r.gap   = gap;
    pending_requests.push_back(r);
  endfunction

  // Work out the reply to one accepted request and update the mirror.
  function automatic void predict_cache_reply(cache_req_t r);
    res_t        res;
    int          i;
    int          slot;
    bit          found;
    logic [31:0] idx_bits;
    res   = '0;
    found = 1'b0;
    if (r.act == ACT_LOOKUP) begin
      n_lookup++;
      for (i = 0; i < fill_level && !found; i++) begin
        if (key_mem[i] == r.key) begin
          found = 1'b1;
          if (use_mem[i] != COUNT_TOP) use_mem[i]++;
          if (use_mem[i] > peak_count) peak_count = use_mem[i];
          idx_bits        = i;
          res.hit         = 1'b1;
          res.entry_index = idx_bits[IDX_OUT_W-1:0];
          res.found_caddr = caddr_mem[i];
          res.found_clen  = clen_mem[i];
          res.found_glen  = glen_mem[i];
        end
      end
      if (found) n_hit++;
    end else begin
      n_insert++;
      if (fill_level < ENTRIES) begin
        slot = fill_level;
        fill_level++;
      end else begin
        // full: least used row goes, lowest index on a tie
        slot = 0;
        for (i = 1; i < fill_level; i++)
          if (use_mem[i] < use_mem[slot]) slot = i;
        res.evicted  = 1'b1;
        res.ev_caddr = caddr_mem[slot];
        res.ev_clen  = clen_mem[slot];
        n_evict++;
      end
      key_mem[slot]   = r.key;
      glen_mem[slot]  = r.glen;
      caddr_mem[slot] = r.caddr;
      clen_mem[slot]  = r.clen;
      use_mem[slot]   = '0;
      idx_bits        = slot;
      res.entry_index = idx_bits[IDX_OUT_W-1:0];
    end
    expected_replies.push_back(res);
  endfunction

  task automatic note_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("reply %0d: %s expected 0x%0h, got 0x%0h", replies_seen, name, want, got);
    end
  endtask

  task automatic check_reply(input res_t got);
    res_t want;
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("reply %0d: word with nothing expected", replies_seen);
    end else begin
      want = expected_replies.pop_front();
      note_field("hit",                  64'(want.hit),         64'(got.hit));
      note_field("entry_index",          64'(want.entry_index), 64'(got.entry_index));
      note_field("found_code_address",   64'(want.found_caddr), 64'(got.found_caddr));
      note_field("found_code_length",    64'(want.found_clen),  64'(got.found_clen));
      note_field("found_guest_length",   64'(want.found_glen),  64'(got.found_glen));
      note_field("evicted",              64'(want.evicted),     64'(got.evicted));
      note_field("evicted_code_address", 64'(want.ev_caddr),    64'(got.ev_caddr));
      note_field("evicted_code_length",  64'(want.ev_clen),     64'(got.ev_clen));
    end
  endtask

  // Driver: offers queued requests after their gaps; the mirror moves on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      gap_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_cache_reply(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (gap_count < pending_requests[0].gap) begin
          gap_count++;
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req   = pending_requests.pop_front();
          gap_count = 0;
          s_axis_tdata  <= {cur_req.clen, cur_req.caddr, cur_req.glen, cur_req.key};
          s_axis_tuser  <= cur_req.act;
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor and receiver: checks each reply word, then picks next cycle's tready.
  // Stalls are random, except for one long hold-off and no stalls during the
  // hot-row burst.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      replies_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_reply.hit         = m_axis_tuser[0];
        seen_reply.evicted     = m_axis_tuser[1];
        seen_reply.entry_index = m_axis_tdata[7:0];
        seen_reply.found_caddr = m_axis_tdata[55:8];
        seen_reply.found_clen  = m_axis_tdata[79:56];
        seen_reply.found_glen  = m_axis_tdata[103:80];
        seen_reply.ev_caddr    = m_axis_tdata[151:104];
        seen_reply.ev_clen     = m_axis_tdata[175:152];
        check_reply(seen_reply);
        replies_seen++;
      end
      if (!hold_done && replies_seen == hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (replies_seen >= sat_lo && replies_seen < sat_hi) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        if (stall_left != 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG);
      $display("translation_block_cache_lfu_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int               i, r, words;
    logic [63:0]      ka, kb, kc, kd;
    logic [63:0]      rk, rg, rc, rl;
    fill_level  = 0;
    mismatches  = 0;
    idle_cycles = 0;
    n_lookup    = 0;
    n_hit       = 0;
    n_insert    = 0;
    n_evict     = 0;
    peak_count  = '0;
    ka = '0;
    kb = '1;
    kc = 64'hAAAA_AAAA_AAAA_AAAA;
    kd = 64'h5555_5555_5555_5555;

    // Directed: empty-table miss, field extremes, duplicate key, misses, hits.
    queue_req(ACT_LOOKUP, ka, '0, '0, '0, 0);
    queue_req(ACT_INSERT, ka, '0, '0, '0, pick_gap());
    queue_req(ACT_INSERT, kb, '1, '1, '1, pick_gap());
    queue_req(ACT_INSERT, kc, kc[GLEN_W-1:0], kc[CADDR_W-1:0], kc[CLEN_W-1:0], pick_gap());
    queue_req(ACT_INSERT, kd, kd[GLEN_W-1:0], kd[CADDR_W-1:0], kd[CLEN_W-1:0], pick_gap());
    // same key again: lookups must still find the lower row
    queue_req(ACT_INSERT, ka, 24'd1, 48'd1, 24'd1, pick_gap());
    queue_req(ACT_LOOKUP, ka, '0, '0, '0, pick_gap());
    queue_req(ACT_LOOKUP, kb, '0, '0, '0, pick_gap());
    queue_req(ACT_LOOKUP, kc, '1, '1, '1, pick_gap());
    queue_req(ACT_LOOKUP, kd, '0, '0, '0, pick_gap());
    queue_req(ACT_LOOKUP, 64'd1, '0, '0, '0, pick_gap());
    queue_req(ACT_LOOKUP, 64'h8000_0000_0000_0000, '0, '0, '0, pick_gap());
    queue_req(ACT_LOOKUP, kb, '0, '0, '0, 0);
    queue_req(ACT_LOOKUP, kb, '0, '0, '0, 0);
    known_keys = '{ka, kb, kc, kd};

    // Hot-row burst: back-to-back hits on row 0, no idling.
    sat_lo = pending_requests.size();
    for (i = 0; i < SAT_HITS; i++) queue_req(ACT_LOOKUP, ka, '0, '0, '0, 0);
    sat_hi  = pending_requests.size();
    hold_at = sat_hi + 40;

    // Random: inserts and lookups of known keys in equal shares; inserts fill the
    // table and then evict, with a share of duplicate keys and misses as noise.
    for (words = 0; words < RAND_WORDS; words++) begin
      r  = $urandom_range(0, 99);
      rk = rand64();
      rg = rand64();
      rc = rand64();
      rl = rand64();
      if (r < 45) begin
        if ($urandom_range(0, 99) < 15)
          rk = known_keys[$urandom_range(0, known_keys.size() - 1)];
        else
          known_keys.push_back(rk);
        queue_req(ACT_INSERT, rk, rg[GLEN_W-1:0], rc[CADDR_W-1:0], rl[CLEN_W-1:0],
                  pick_gap());
      end else if (r < 90) begin
        queue_req(ACT_LOOKUP, known_keys[$urandom_range(0, known_keys.size() - 1)],
                  rg[GLEN_W-1:0], rc[CADDR_W-1:0], rl[CLEN_W-1:0], pick_gap());
      end else begin
        queue_req(ACT_LOOKUP, rk, rg[GLEN_W-1:0], rc[CADDR_W-1:0], rl[CLEN_W-1:0],
                  pick_gap());
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
    // a late word would show up as unexpected here
    repeat (ENTRIES + 16) @(negedge clk_i);

    mismatches += expected_replies.size();
    $display("run covered %0d lookups (%0d hits) and %0d inserts (%0d evictions)",
             n_lookup, n_hit, n_insert, n_evict);
    $display("peak use count %0d of %0d, %0d mismatching fields", peak_count, COUNT_TOP,
             mismatches);
    if (mismatches == 0)
      $display("translation_block_cache_lfu_tb: done, clean");
    else
      $display("translation_block_cache_lfu_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tbc_pkg.sv
src/tbc_ram.sv
src/tbc_front.sv
src/tbc_back.sv
src/translation_block_cache_lfu.sv
tb/translation_block_cache_lfu_tb.sv
